FILE: src/lfvc_pkg.sv
package lfvc_pkg;

	localparam int MaxWidth = 1024;
	localparam int MaxHeight = 1024;
	localparam int HitW = 11;
	localparam int SumW = 20;
	localparam logic [HitW-1:0] HitMax = 11'd2047;
	localparam logic [SumW-1:0] SumMax = 20'hFFFFF;
	localparam logic signed [20:0] TurnLim = 21'sd786432;
	localparam logic signed [20:0] RecoverTurn = 21'sd8192;

	localparam logic [2:0] CfgWidth = 3'd0;
	localparam logic [2:0] CfgNear = 3'd1;
	localparam logic [2:0] CfgC0 = 3'd2;
	localparam logic [2:0] CfgC1 = 3'd3;
	localparam logic [2:0] CfgC2 = 3'd4;

	typedef enum logic [2:0] {
		MODE_FAST = 3'd0,
		MODE_BRAKE = 3'd1,
		MODE_FCURVE = 3'd2,
		MODE_SCURVE = 3'd3,
		MODE_RECOVER = 3'd4,
		MODE_APPROACH = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_START,
		ST_DIV,
		ST_ERR,
		ST_MUL,
		ST_OUT
	} seq_t;

	// Request to the shared divider and its answer.
	typedef struct packed {
		logic start;
		logic [SumW-1:0] num;
		logic [HitW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [SumW-1:0] quo;
	} div_rsp_t;

endpackage

FILE: src/lfvc_div.sv
module lfvc_div (
	input logic clk,
	input logic arst_n,
	input lfvc_pkg::div_req_t req,
	output lfvc_pkg::div_rsp_t rsp
);
	// Restoring division, one quotient bit per cycle.
	logic [lfvc_pkg::SumW-1:0] num_q;
	logic [lfvc_pkg::HitW:0] rem_q;
	logic [lfvc_pkg::HitW-1:0] den_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [lfvc_pkg::HitW:0] trial;
	logic [lfvc_pkg::HitW:0] sub;

	assign trial = {rem_q[lfvc_pkg::HitW-1:0], num_q[lfvc_pkg::SumW-1]};
	assign sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(lfvc_pkg::SumW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!sub[lfvc_pkg::HitW]) begin
				rem_q <= sub;
				num_q <= {num_q[lfvc_pkg::SumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[lfvc_pkg::SumW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = num_q;
endmodule

FILE: src/line_follow_vision_controller.sv
// Channel  | Valid      | Backpressure | Payload
// pixel in | in_valid   | in_stall     | pixel_c0..c2, column, row, frame_end
// result   | out_valid  | out_stall    | mode .. far_error
// config   | cfg_valid  | cfg_ready    | cfg_index, cfg_data
// Pixels without frame_end are taken at one per cycle while the block is accumulating.
// On frame_end the input stalls: a start state launches the shared divider, then each of the
// three rows takes a 20-step division and an error step, then a multiply state waits for
// the registered product and an output state loads the result beat.
// The output cycle waits while an earlier result beat is still stalled, and pixels are
// taken again as soon as the new result is loaded.
// Reset restores recover mode and the register defaults.
module line_follow_vision_controller (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] pixel_c0,
	input logic [7:0] pixel_c1,
	input logic [7:0] pixel_c2,
	input logic [9:0] column,
	input logic [9:0] row,
	input logic frame_end,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] mode,
	output logic [7:0] drive_speed,
	output logic signed [20:0] turn_rate,
	output logic turn_updated,
	output logic signed [10:0] near_error,
	output logic signed [10:0] mid_error,
	output logic signed [10:0] far_error,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [10:0] cfg_data
);
	logic [10:0] width_q;
	logic [9:0] near_q;
	logic [7:0] c0_q, c1_q, c2_q;
	lfvc_pkg::mode_t cur_q;
	logic [2:0] brake_q, stable_q;
	logic signed [10:0] last_q;
	logic [9:0] mid_q, far_q;
	logic [lfvc_pkg::HitW-1:0] hit_q [3];
	logic [lfvc_pkg::SumW-1:0] sum_q [3];
	logic signed [10:0] err_q [3];
	lfvc_pkg::seq_t st_q, st_d;
	logic [1:0] k_q;
	logic out_v_q;
	logic [2:0] omode_q;
	logic [7:0] ospeed_q;
	logic signed [20:0] oturn_q;
	logic oupd_q;
	logic signed [10:0] mul_e_q;
	logic signed [15:0] mul_g_q;
	logic signed [26:0] prod_q;
	logic mul_en_q;
	lfvc_pkg::div_req_t dreq;
	lfvc_pkg::div_rsp_t drsp;

	lfvc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != lfvc_pkg::ST_ACC);

	logic [10:0] wid;
	logic [10:0] centre;
	always_comb begin
		wid = width_q;
		if (wid < 11'd2) wid = 11'd2;
		if (wid > 11'(lfvc_pkg::MaxWidth)) wid = 11'(lfvc_pkg::MaxWidth);
		centre = {1'b0, wid[10:1]};
	end

	logic acc_ok, is_line;
	logic [2:0] hit_row;
	always_comb begin
		acc_ok = ({1'b0, column} < wid) && (row >= far_q);
		is_line = (pixel_c0 > c0_q && pixel_c1 < c1_q && pixel_c2 < c2_q) ||
			(pixel_c0 == 8'd0 && pixel_c1 == 8'd254 && pixel_c2 == 8'd254);
		hit_row[0] = row == near_q;
		hit_row[1] = row == mid_q;
		hit_row[2] = row == far_q;
	end

	logic take;
	assign take = in_valid && !in_stall;

	// Error from divider quotient.
	logic signed [21:0] err_w;
	logic signed [10:0] err_sat;
	always_comb begin
		err_w = $signed({11'd0, centre}) -
			$signed({2'b0, (hit_q[k_q] != '0) ? drsp.quo : 20'd0});
		if (err_w > 22'sd512) err_sat = 11'sd512;
		else if (err_w < -22'sd511) err_sat = -11'sd511;
		else err_sat = err_w[10:0];
	end

	// The first division starts in the cycle after the frame_end pixel is taken, so that its pixel is counted.
	always_comb begin
		dreq.start = 1'b0;
		dreq.num = sum_q[k_q];
		dreq.den = (hit_q[k_q] == '0) ? 11'd1 : hit_q[k_q];
		if (st_q == lfvc_pkg::ST_START) begin
			dreq.start = 1'b1;
		end else if (st_q == lfvc_pkg::ST_ERR && k_q != 2'd2) begin
			dreq.start = 1'b1;
			dreq.num = sum_q[k_q + 2'd1];
			dreq.den = (hit_q[k_q + 2'd1] == '0) ? 11'd1 : hit_q[k_q + 2'd1];
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			lfvc_pkg::ST_ACC: if (take && frame_end) st_d = lfvc_pkg::ST_START;
			lfvc_pkg::ST_START: st_d = lfvc_pkg::ST_DIV;
			lfvc_pkg::ST_DIV: if (drsp.done) st_d = lfvc_pkg::ST_ERR;
			lfvc_pkg::ST_ERR: st_d = (k_q == 2'd2) ? lfvc_pkg::ST_MUL : lfvc_pkg::ST_DIV;
			lfvc_pkg::ST_MUL: if (mul_en_q) st_d = lfvc_pkg::ST_OUT;
			lfvc_pkg::ST_OUT: if (!out_v_q || !out_stall) st_d = lfvc_pkg::ST_ACC;
			default: st_d = lfvc_pkg::ST_ACC;
		endcase
	end

	// Mode decision on registered errors.
	logic h1, h2, h3;
	logic signed [10:0] e1, e2, e3;
	logic [10:0] a1, a2, a3;
	lfvc_pkg::mode_t nm;
	logic [7:0] spd;
	logic upd, use_mul;
	logic signed [20:0] fixed_turn;
	logic signed [10:0] sel_e;
	logic signed [15:0] sel_g;
	logic [2:0] nbrake, nstable;
	logic [9:0] nmid, nfar;
	always_comb begin
		h1 = hit_q[0] != '0;
		h2 = hit_q[1] != '0;
		h3 = hit_q[2] != '0;
		e1 = err_q[0];
		e2 = err_q[1];
		e3 = err_q[2];
		a1 = e1[10] ? 11'(-e1) : e1;
		a2 = e2[10] ? 11'(-e2) : e2;
		a3 = e3[10] ? 11'(-e3) : e3;
		nm = cur_q;
		spd = 8'd0;
		upd = 1'b0;
		use_mul = 1'b0;
		fixed_turn = '0;
		sel_e = e2;
		sel_g = 16'sd0;
		nbrake = brake_q;
		nstable = stable_q;
		nmid = mid_q;
		nfar = far_q;
		unique case (cur_q)
			lfvc_pkg::MODE_FAST: begin
				nfar = 10'd295; nmid = 10'd350; spd = 8'd130;
				upd = 1'b1; use_mul = 1'b1; sel_e = e2; sel_g = 16'sd115;
				if (!h1 && !h2 && !h3) nm = lfvc_pkg::MODE_RECOVER;
				else if (a3 > 11'd100 || e2 > 11'sd100) begin
					nm = lfvc_pkg::MODE_BRAKE; nbrake = 3'd0;
				end
			end
			lfvc_pkg::MODE_BRAKE: begin
				nmid = 10'd400; nfar = 10'd370; spd = 8'd1;
				if (h3) begin upd = 1'b1; use_mul = 1'b1; sel_e = e3; sel_g = 16'sd24576; end
				else if (h2) begin upd = 1'b1; use_mul = 1'b1; sel_e = e2; sel_g = 16'sd24576; end
				if (brake_q > 3'd3)
					nm = (h1 && h2 && h3) ? lfvc_pkg::MODE_RECOVER : lfvc_pkg::MODE_SCURVE;
				else nbrake = brake_q + 3'd1;
			end
			lfvc_pkg::MODE_FCURVE: begin
				nmid = 10'd392; nfar = 10'd325; spd = 8'd65;
				if (h2) begin upd = 1'b1; use_mul = 1'b1; sel_e = e2; sel_g = 16'sd328; end
				if (!h1 && !h2 && !h3) begin nm = lfvc_pkg::MODE_RECOVER; nstable = 3'd0; end
				else if (a3 > 11'd150) begin nm = lfvc_pkg::MODE_SCURVE; nstable = 3'd0; end
				else if (a2 < 11'd30 && a3 < 11'd55 && a1 < 11'd30) begin
					if (stable_q > 3'd5) begin nm = lfvc_pkg::MODE_FAST; nstable = 3'd0; end
					else nstable = stable_q + 3'd1;
				end else nstable = 3'd0;
			end
			lfvc_pkg::MODE_SCURVE: begin
				nmid = 10'd392; nfar = 10'd360; spd = 8'd48;
				if (h3) begin upd = 1'b1; use_mul = 1'b1; sel_e = e3; sel_g = 16'sd737; end
				else if (h2) begin upd = 1'b1; use_mul = 1'b1; sel_e = e2; sel_g = 16'sd590; end
				else if (h1) begin upd = 1'b1; use_mul = 1'b1; sel_e = e1; sel_g = 16'sd475; end
				else nm = lfvc_pkg::MODE_RECOVER;
				if (a2 < 11'd80 && a3 < 11'd180) nm = lfvc_pkg::MODE_FCURVE;
			end
			lfvc_pkg::MODE_APPROACH: begin
				spd = 8'd15; upd = 1'b1; use_mul = 1'b1; sel_e = e3; sel_g = 16'sd393;
				if (h2) nm = lfvc_pkg::MODE_SCURVE;
			end
			default: begin
				nfar = 10'd340; spd = 8'd2;
				if (last_q != 11'sd0) begin
					upd = 1'b1;
					fixed_turn = (last_q > 11'sd0) ? lfvc_pkg::RecoverTurn : -lfvc_pkg::RecoverTurn;
				end
				if (h3) nm = lfvc_pkg::MODE_APPROACH;
			end
		endcase
	end

	// Product / 16 toward zero, saturated.
	logic signed [26:0] qv;
	logic signed [20:0] turn_sat;
	always_comb begin
		qv = (prod_q + (prod_q[26] ? 27'sd15 : 27'sd0)) >>> 4;
		if (qv > 27'(lfvc_pkg::TurnLim)) turn_sat = lfvc_pkg::TurnLim;
		else if (qv < -27'(lfvc_pkg::TurnLim)) turn_sat = -lfvc_pkg::TurnLim;
		else turn_sat = qv[20:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd640; near_q <= 10'd478;
			c0_q <= 8'd45; c1_q <= 8'd25; c2_q <= 8'd25;
			cur_q <= lfvc_pkg::MODE_RECOVER;
			brake_q <= '0; stable_q <= '0; last_q <= '0;
			mid_q <= 10'd382; far_q <= 10'd320;
			for (int i = 0; i < 3; i++) begin
				hit_q[i] <= '0; sum_q[i] <= '0;
			end
			st_q <= lfvc_pkg::ST_ACC;
			k_q <= '0; out_v_q <= 1'b0; mul_en_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					lfvc_pkg::CfgWidth: width_q <= cfg_data;
					lfvc_pkg::CfgNear: near_q <= cfg_data[9:0];
					lfvc_pkg::CfgC0: c0_q <= cfg_data[7:0];
					lfvc_pkg::CfgC1: c1_q <= cfg_data[7:0];
					lfvc_pkg::CfgC2: c2_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_v_q && !out_stall &&
					!(st_q == lfvc_pkg::ST_OUT && st_d == lfvc_pkg::ST_ACC))
				out_v_q <= 1'b0;
			if (take && acc_ok && is_line) begin
				for (int i = 0; i < 3; i++) begin
					if (hit_row[i]) begin
						if (hit_q[i] != lfvc_pkg::HitMax) hit_q[i] <= hit_q[i] + 11'd1;
						if (sum_q[i] > lfvc_pkg::SumMax - {10'd0, column})
							sum_q[i] <= lfvc_pkg::SumMax;
						else sum_q[i] <= sum_q[i] + {10'd0, column};
					end
				end
			end
			if (st_q == lfvc_pkg::ST_ACC) k_q <= '0;
			if (st_q == lfvc_pkg::ST_ERR && k_q != 2'd2) k_q <= k_q + 2'd1;
			mul_en_q <= (st_q == lfvc_pkg::ST_MUL);
			if (st_q == lfvc_pkg::ST_OUT && st_d == lfvc_pkg::ST_ACC) begin
				out_v_q <= 1'b1;
				cur_q <= nm; brake_q <= nbrake; stable_q <= nstable;
				mid_q <= nmid; far_q <= nfar;
				if (h2) last_q <= e2;
				for (int i = 0; i < 3; i++) begin
					hit_q[i] <= '0; sum_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == lfvc_pkg::ST_ERR) err_q[k_q] <= err_sat;
		if (st_q == lfvc_pkg::ST_MUL) prod_q <= 27'(sel_e * sel_g);
		if (st_q == lfvc_pkg::ST_OUT && st_d == lfvc_pkg::ST_ACC) begin
			omode_q <= nm;
			ospeed_q <= spd;
			oupd_q <= upd;
			oturn_q <= !upd ? 21'sd0 : (use_mul ? turn_sat : fixed_turn);
			near_error <= e1; mid_error <= e2; far_error <= e3;
		end
	end

	assign out_valid = out_v_q;
	assign mode = omode_q;
	assign drive_speed = ospeed_q;
	assign turn_rate = oturn_q;
	assign turn_updated = oupd_q;
endmodule

FILE: bench/tb_line_follow_vision_controller.sv
`timescale 1ns / 1ps

typedef struct {
	logic [2:0] mode;
	logic [7:0] speed;
	logic signed [20:0] turn;
	logic upd;
	logic signed [10:0] near_e;
	logic signed [10:0] mid_e;
	logic signed [10:0] far_e;
} decision_t;

// Tracks the steering decision the block should make at each frame end.
class decision_board;
	int frame_width, near_row, c0_min, c1_max, c2_max;
	lfvc_pkg::mode_t cur_mode;
	int brake_cnt, stable_cnt, last_mid, mid_idx, far_idx;
	int hits[3];
	int sums[3];
	decision_t pending[$];
	int errors;

	function new();
		frame_width = 640;
		near_row = 478;
		c0_min = 45;
		c1_max = 25;
		c2_max = 25;
		cur_mode = lfvc_pkg::MODE_RECOVER;
		brake_cnt = 0;
		stable_cnt = 0;
		last_mid = 0;
		mid_idx = 382;
		far_idx = 320;
		errors = 0;
		for (int k = 0; k < 3; k++) begin
			hits[k] = 0;
			sums[k] = 0;
		end
	endfunction

	function void write_reg(logic [2:0] idx, logic [10:0] data);
		case (idx)
			lfvc_pkg::CfgWidth: frame_width = int'(data);
			lfvc_pkg::CfgNear: near_row = int'(data[9:0]);
			lfvc_pkg::CfgC0: c0_min = int'(data[7:0]);
			lfvc_pkg::CfgC1: c1_max = int'(data[7:0]);
			lfvc_pkg::CfgC2: c2_max = int'(data[7:0]);
			default: ;
		endcase
	endfunction

	function int clamped_width();
		if (frame_width < 2)
			return 2;
		if (frame_width > lfvc_pkg::MaxWidth)
			return lfvc_pkg::MaxWidth;
		return frame_width;
	endfunction

	function int mag(int v);
		return v < 0 ? -v : v;
	endfunction

	function int steer(int err, int gain);
		longint q;
		q = (longint'(err) * gain) / 16;
		if (q > 786432)
			q = 786432;
		if (q < -786432)
			q = -786432;
		return int'(q);
	endfunction

	function void add_hit(int k, int col);
		if (hits[k] < int'(lfvc_pkg::HitMax))
			hits[k]++;
		if (sums[k] > int'(lfvc_pkg::SumMax) - col)
			sums[k] = int'(lfvc_pkg::SumMax);
		else
			sums[k] += col;
	endfunction

	function int row_err(int k, int centre);
		int e;
		e = centre - (hits[k] != 0 ? sums[k] / hits[k] : 0);
		if (e > 512)
			e = 512;
		if (e < -511)
			e = -511;
		return e;
	endfunction

	function void note_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
			logic [9:0] col, logic [9:0] row, logic fe);
		int w, centre, speed, turn;
		int e[3];
		bit h[3];
		bit upd;
		lfvc_pkg::mode_t md;
		decision_t d;
		w = clamped_width();
		if (col < w && row >= far_idx) begin
			if ((c0 > c0_min && c1 < c1_max && c2 < c2_max) ||
					(c0 == 0 && c1 == 254 && c2 == 254)) begin
				if (row == near_row)
					add_hit(0, col);
				if (row == mid_idx)
					add_hit(1, col);
				if (row == far_idx)
					add_hit(2, col);
			end
		end
		if (!fe)
			return;
		centre = w / 2;
		for (int k = 0; k < 3; k++) begin
			e[k] = row_err(k, centre);
			h[k] = hits[k] != 0;
		end
		md = cur_mode;
		speed = 0;
		turn = 0;
		upd = 0;
		case (cur_mode)
			lfvc_pkg::MODE_FAST: begin
				far_idx = 295;
				mid_idx = 350;
				speed = 130;
				turn = steer(e[1], 115);
				upd = 1;
				if (!h[0] && !h[1] && !h[2])
					md = lfvc_pkg::MODE_RECOVER;
				else if (mag(e[2]) > 100 || e[1] > 100) begin
					md = lfvc_pkg::MODE_BRAKE;
					brake_cnt = 0;
				end
			end
			lfvc_pkg::MODE_BRAKE: begin
				mid_idx = 400;
				far_idx = 370;
				speed = 1;
				if (h[2]) begin
					turn = steer(e[2], 24576);
					upd = 1;
				end else if (h[1]) begin
					turn = steer(e[1], 24576);
					upd = 1;
				end
				if (brake_cnt > 3)
					md = (h[0] && h[1] && h[2]) ? lfvc_pkg::MODE_RECOVER : lfvc_pkg::MODE_SCURVE;
				else
					brake_cnt++;
			end
			lfvc_pkg::MODE_FCURVE: begin
				mid_idx = 392;
				far_idx = 325;
				speed = 65;
				if (h[1]) begin
					turn = steer(e[1], 328);
					upd = 1;
				end
				if (!h[0] && !h[1] && !h[2]) begin
					md = lfvc_pkg::MODE_RECOVER;
					stable_cnt = 0;
				end else if (mag(e[2]) > 150) begin
					md = lfvc_pkg::MODE_SCURVE;
					stable_cnt = 0;
				end else if (mag(e[1]) < 30 && mag(e[2]) < 55 && mag(e[0]) < 30) begin
					if (stable_cnt > 5) begin
						md = lfvc_pkg::MODE_FAST;
						stable_cnt = 0;
					end else
						stable_cnt++;
				end else
					stable_cnt = 0;
			end
			lfvc_pkg::MODE_SCURVE: begin
				mid_idx = 392;
				far_idx = 360;
				speed = 48;
				upd = 1;
				if (h[2])
					turn = steer(e[2], 737);
				else if (h[1])
					turn = steer(e[1], 590);
				else if (h[0])
					turn = steer(e[0], 475);
				else begin
					upd = 0;
					md = lfvc_pkg::MODE_RECOVER;
				end
				if (mag(e[1]) < 80 && mag(e[2]) < 180)
					md = lfvc_pkg::MODE_FCURVE;
			end
			lfvc_pkg::MODE_APPROACH: begin
				speed = 15;
				turn = steer(e[2], 393);
				upd = 1;
				if (h[1])
					md = lfvc_pkg::MODE_SCURVE;
			end
			default: begin
				far_idx = 340;
				speed = 2;
				if (last_mid != 0) begin
					turn = last_mid > 0 ? int'(lfvc_pkg::RecoverTurn)
							: -int'(lfvc_pkg::RecoverTurn);
					upd = 1;
				end
				if (h[2])
					md = lfvc_pkg::MODE_APPROACH;
			end
		endcase
		if (h[1])
			last_mid = e[1];
		cur_mode = md;
		for (int k = 0; k < 3; k++) begin
			hits[k] = 0;
			sums[k] = 0;
		end
		d.mode = md;
		d.speed = 8'(speed);
		d.turn = 21'(turn);
		d.upd = upd;
		d.near_e = 11'(e[0]);
		d.mid_e = 11'(e[1]);
		d.far_e = 11'(e[2]);
		pending.push_back(d);
	endfunction

	function void check_result(decision_t got);
		decision_t want;
		if (pending.size() == 0) begin
			$error("decision beat with none outstanding");
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.mode !== want.mode) begin
			$error("mode: expected %0d, got %0d", want.mode, got.mode);
			errors++;
		end
		if (got.speed !== want.speed) begin
			$error("drive_speed: expected %0d, got %0d", want.speed, got.speed);
			errors++;
		end
		if (got.turn !== want.turn) begin
			$error("turn_rate: expected %0d, got %0d", want.turn, got.turn);
			errors++;
		end
		if (got.upd !== want.upd) begin
			$error("turn_updated: expected %0d, got %0d", want.upd, got.upd);
			errors++;
		end
		if (got.near_e !== want.near_e) begin
			$error("near_error: expected %0d, got %0d", want.near_e, got.near_e);
			errors++;
		end
		if (got.mid_e !== want.mid_e) begin
			$error("mid_error: expected %0d, got %0d", want.mid_e, got.mid_e);
			errors++;
		end
		if (got.far_e !== want.far_e) begin
			$error("far_error: expected %0d, got %0d", want.far_e, got.far_e);
			errors++;
		end
	endfunction
endclass

module tb_line_follow_vision_controller;
	localparam int StallLimit = 20000;
	localparam int SettleCycles = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] pixel_c0 = '0;
	logic [7:0] pixel_c1 = '0;
	logic [7:0] pixel_c2 = '0;
	logic [9:0] column = '0;
	logic [9:0] row = '0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] mode;
	logic [7:0] drive_speed;
	logic signed [20:0] turn_rate;
	logic turn_updated;
	logic signed [10:0] near_error, mid_error, far_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [10:0] cfg_data = '0;

	decision_board board = new();
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int quiet_cycles = 0;
	int sent = 0;

	line_follow_vision_controller uut (.*);

	always #10 clk = ~clk;

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

	always @(posedge clk) begin
		decision_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.mode = mode;
			got.speed = drive_speed;
			got.turn = turn_rate;
			got.upd = turn_updated;
			got.near_e = near_error;
			got.mid_e = mid_error;
			got.far_e = far_error;
			board.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("line_follow_vision_controller verification failed");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
			input int col, input int rw, input bit fe);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel_c0 = c0;
		pixel_c1 = c1;
		pixel_c2 = c2;
		column = 10'(col);
		row = 10'(rw);
		frame_end = fe;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_pixel(c0, c1, c2, column, row, fe);
		sent++;
	endtask

	// Hold the pixel stream until every decision is out and the block has gone quiet.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = 11'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(idx, cfg_data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_regs(input int w, input int nr, input int t0, input int t1, input int t2);
		drain();
		write_reg(lfvc_pkg::CfgWidth, w);
		write_reg(lfvc_pkg::CfgNear, nr);
		write_reg(lfvc_pkg::CfgC0, t0);
		write_reg(lfvc_pkg::CfgC1, t1);
		write_reg(lfvc_pkg::CfgC2, t2);
	endtask

	function automatic int sampled_row();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return board.near_row;
		if (pick < 5)
			return board.mid_idx;
		if (pick < 8)
			return board.far_idx;
		return $urandom_range(0, 1023);
	endfunction

	task automatic random_pixel(input int col, input int rw, input bit fe);
		int pick;
		logic [7:0] c0, c1, c2;
		pick = $urandom_range(0, 99);
		c0 = 8'($urandom);
		c1 = 8'($urandom);
		c2 = 8'($urandom);
		if (pick < 55) begin
			c0 = 8'($urandom_range(board.c0_min < 255 ? board.c0_min + 1 : 255, 255));
			c1 = 8'($urandom_range(0, board.c1_max > 0 ? board.c1_max - 1 : 0));
			c2 = 8'($urandom_range(0, board.c2_max > 0 ? board.c2_max - 1 : 0));
		end else if (pick < 65) begin
			c0 = 8'd0;
			c1 = 8'd254;
			c2 = 8'd254;
		end
		send_pixel(c0, c1, c2, col, rw, fe);
	endtask

	// Frames whose sampled rows carry a line near a per-frame offset from centre.
	task automatic random_frames(input int budget);
		int stop, len, spread, centre, rw, col;
		int base[3];
		stop = sent + budget;
		while (sent < stop) begin
			len = $urandom_range(2, 18);
			centre = board.clamped_width() / 2;
			case ($urandom_range(0, 5))
				0, 1, 2: spread = 12;
				3: spread = 80;
				4: spread = 250;
				default: spread = 700;
			endcase
			for (int k = 0; k < 3; k++)
				base[k] = centre + int'($urandom_range(0, 2 * spread)) - spread;
			for (int i = 0; i < len; i++) begin
				rw = sampled_row();
				col = $urandom_range(0, 1023);
				if ($urandom_range(0, 9) < 8) begin
					col = (rw == board.near_row) ? base[0] : (rw == board.mid_idx) ? base[1]
							: base[2];
					col += int'($urandom_range(0, 6)) - 3;
				end
				if (col < 0)
					col = 0;
				if (col > 1023)
					col = 1023;
				random_pixel(col, rw, i == len - 1);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int seg = 0; seg < 6; seg++) begin
			if (seg < 2) begin
				tx_idle_pct = 31;
				rx_idle_pct = 80;
			end else if (seg < 4) begin
				tx_idle_pct = 80;
				rx_idle_pct = 31;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (seg)
				0: set_regs(640, 478, 45, 25, 25);
				2: set_regs(1, 0, 255, 0, 0);
				4: set_regs(2047, 1023, 0, 255, 255);
				5: set_regs($urandom_range(0, 2047), $urandom_range(0, 1023), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				default: set_regs($urandom_range(100, 1024), 340 + 10 * $urandom_range(0, 6),
						$urandom_range(20, 80), $urandom_range(10, 60), $urandom_range(10, 60));
			endcase
			if (seg == 0) begin
				// Empty frame in recover mode, then a far-row hit that moves to approach.
				send_pixel(8'd0, 8'd0, 8'd0, 0, 0, 1'b1);
				send_pixel(8'd0, 8'd254, 8'd254, 10, 340, 1'b0);
				send_pixel(8'd255, 8'd0, 8'd0, 639, 340, 1'b0);
				send_pixel(8'd255, 8'd0, 8'd0, 640, 340, 1'b0);
				send_pixel(8'd255, 8'd0, 8'd0, 1023, 339, 1'b0);
				send_pixel(8'd200, 8'd0, 8'd0, 300, 0, 1'b0);
				send_pixel(8'd46, 8'd24, 8'd24, 320, 340, 1'b1);
				send_pixel(8'd45, 8'd24, 8'd24, 20, 340, 1'b0);
				send_pixel(8'd46, 8'd25, 8'd24, 20, 340, 1'b0);
				send_pixel(8'd46, 8'd24, 8'd25, 20, 340, 1'b0);
				send_pixel(8'd100, 8'd1, 8'd1, 0, 382, 1'b0);
				send_pixel(8'd255, 8'd255, 8'd255, 600, 340, 1'b1);
				send_pixel(8'd90, 8'd5, 8'd5, 320, 360, 1'b0);
				send_pixel(8'd90, 8'd5, 8'd5, 330, 392, 1'b0);
				send_pixel(8'd90, 8'd5, 8'd5, 310, 478, 1'b0);
				send_pixel(8'd0, 8'd254, 8'd253, 0, 360, 1'b1);
				drain();
			end
			random_frames(140);
		end

		drain();
		if (board.errors == 0)
			$display("line_follow_vision_controller verification clean");
		else
			$display("line_follow_vision_controller verification failed");
		$finish;
	end
endmodule
